// ===== rtl/core/jvcs_pkg.sv =====
package jvcs_pkg;

   localparam int unsigned LEVEL_W   = 16;
   localparam int unsigned CMD_W     = 16;
   localparam int unsigned DBAND_W   = 15;
   localparam int unsigned STEP_W    = 16;
   localparam int unsigned GCNT_W    = 6;
   localparam int unsigned CSR_AW    = 4;
   localparam int unsigned CSR_DW    = 32;
   localparam int unsigned WIDE_W    = 18;

   localparam logic [DBAND_W-1:0] DBAND_RESET = 15'd6554;
   localparam logic [STEP_W-1:0]  ACCEL_RESET = 16'd33;
   localparam logic [STEP_W-1:0]  DECEL_RESET = 16'd98;

   typedef enum logic [1:0] {
      REG_DEADBAND = 2'd0,
      REG_ACCEL    = 2'd1,
      REG_DECEL    = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [DBAND_W-1:0] deadband_width;
      logic [STEP_W-1:0]  accel_step;
      logic [STEP_W-1:0]  decel_step;
   } cfg_type;

   typedef struct packed {
      logic signed [CMD_W-1:0] fwd_target;
      logic signed [CMD_W-1:0] turn;
      logic                    gait;
      logic                    ab_pressed;
   } cmd_type;

   function automatic logic [WIDE_W-2:0] abs_wide(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] n;
      n = -v;
      return v[WIDE_W-1] ? n[WIDE_W-2:0] : v[WIDE_W-2:0];
   endfunction

endpackage

// ===== rtl/core/jvcs_if.sv =====
interface jvcs_req_channel;
   logic        valid;
   logic        ready;
   logic [15:0] stick_forward;
   logic [15:0] stick_turn;
   logic [15:0] enable_trigger;
   logic [15:0] gait_trigger;
   logic [15:0] button_a;
   logic [15:0] button_b;
   logic [15:0] hold_forward_button;
   logic [15:0] hold_turn_button;

   modport source (
      output valid, stick_forward, stick_turn, enable_trigger, gait_trigger,
             button_a, button_b, hold_forward_button, hold_turn_button,
      input  ready
   );
   modport sink (
      input  valid, stick_forward, stick_turn, enable_trigger, gait_trigger,
             button_a, button_b, hold_forward_button, hold_turn_button,
      output ready
   );
endinterface

interface jvcs_rsp_channel;
   logic               valid;
   logic               ready;
   logic signed [15:0] forward_velocity;
   logic signed [15:0] turn_rate;
   logic               gait_active;
   logic [15:0]        stride_phase;
   logic               learned_mode;

   modport source (
      output valid, forward_velocity, turn_rate, gait_active, stride_phase, learned_mode,
      input  ready
   );
   modport sink (
      input  valid, forward_velocity, turn_rate, gait_active, stride_phase, learned_mode,
      output ready
   );
endinterface

// ===== rtl/core/jvcs_csr.sv =====
module jvcs_csr
   import jvcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[CSR_AW-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_DEADBAND: cfg_in.deadband_width = pwdata[DBAND_W-1:0];
            REG_ACCEL:    cfg_in.accel_step     = pwdata[STEP_W-1:0];
            REG_DECEL:    cfg_in.decel_step     = pwdata[STEP_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_DEADBAND: prdata = CSR_DW'(cfg_ff.deadband_width);
         REG_ACCEL:    prdata = CSR_DW'(cfg_ff.accel_step);
         REG_DECEL:    prdata = CSR_DW'(cfg_ff.decel_step);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband_width <= DBAND_RESET;
         cfg_ff.accel_step     <= ACCEL_RESET;
         cfg_ff.decel_step     <= DECEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/jvcs_front.sv =====
module jvcs_front
   import jvcs_pkg::*;
(
   jvcs_req_channel.sink     req,
   input  logic [DBAND_W-1:0] deadband_width,
   input  logic               q_ready,
   output logic               q_push,
   output cmd_type            q_cmd
);

   logic enable;
   logic hold_fwd;
   logic hold_turn;

   function automatic logic signed [CMD_W-1:0] stick_cmd(
      input logic [LEVEL_W-1:0]  raw,
      input logic                hold,
      input logic                en,
      input logic [DBAND_W-1:0]  dband
   );
      logic signed [LEVEL_W:0] d;
      logic signed [LEVEL_W:0] half;
      logic [LEVEL_W:0]        mag;
      d    = $signed(17'h08000) - $signed({1'b0, raw});
      mag  = d[LEVEL_W] ? 17'(-d) : 17'(d);
      // halve, rounding toward zero
      half = (d + $signed({16'b0, d[LEVEL_W]})) >>> 1;
      if (hold || !en || mag <= {2'b00, dband})
         return '0;
      return half[CMD_W-1:0];
   endfunction

   assign enable    = req.enable_trigger[LEVEL_W-1];
   assign hold_fwd  = req.hold_forward_button[LEVEL_W-1];
   assign hold_turn = req.hold_turn_button[LEVEL_W-1];

   assign req.ready = q_ready;
   assign q_push    = req.valid && q_ready;

   always_comb begin
      q_cmd.fwd_target = stick_cmd(req.stick_forward, hold_fwd, enable, deadband_width);
      q_cmd.turn       = stick_cmd(req.stick_turn, hold_turn, enable, deadband_width);
      q_cmd.gait       = req.gait_trigger[LEVEL_W-1];
      q_cmd.ab_pressed = req.button_a[LEVEL_W-1] && req.button_b[LEVEL_W-1];
   end

endmodule

// ===== rtl/core/jvcs_queue.sv =====
module jvcs_queue
   import jvcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    push_ready,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/jvcs_back.sv =====
module jvcs_back
   import jvcs_pkg::*;
#(
   parameter int unsigned GAIT_PERIOD_TICKS = 60
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [STEP_W-1:0] accel_step,
   input  logic [STEP_W-1:0] decel_step,
   input  logic              q_valid,
   input  cmd_type           q_cmd,
   output logic              q_pop,
   jvcs_rsp_channel.source   rsp
);

   localparam int unsigned PHASE_INC = 65536 / GAIT_PERIOD_TICKS;
   localparam int unsigned PHASE_REM = 65536 % GAIT_PERIOD_TICKS;

   logic signed [CMD_W-1:0] vel_ff, vel_in;
   logic [GCNT_W-1:0]       gcnt_ff, gcnt_in;
   logic [LEVEL_W-1:0]      gq_ff, gq_in;
   logic [GCNT_W-1:0]       gr_ff, gr_in;
   logic                    latch_ff, latch_in;
   logic                    out_valid_ff, out_valid_in;

   logic signed [CMD_W-1:0] out_fwd_ff;
   logic signed [CMD_W-1:0] out_turn_ff;
   logic                    out_gait_ff;
   logic [LEVEL_W-1:0]      out_phase_ff, phase;

   logic signed [WIDE_W-1:0] cur, tgt, dv, dec_s, acc_s, step_s;
   logic [WIDE_W-2:0]        acur, atgt, adv, step_u;
   logic                     oppose;
   logic [GCNT_W-1:0]        gcnt_inc;
   logic [GCNT_W:0]          rem_sum;

   assign q_pop = q_valid && (!out_valid_ff || rsp.ready);

   assign rsp.valid            = out_valid_ff;
   assign rsp.forward_velocity = out_fwd_ff;
   assign rsp.turn_rate        = out_turn_ff;
   assign rsp.gait_active      = out_gait_ff;
   assign rsp.stride_phase     = out_phase_ff;
   assign rsp.learned_mode     = latch_ff;

   // slew limiter
   always_comb begin
      cur    = WIDE_W'(vel_ff);
      tgt    = WIDE_W'(q_cmd.fwd_target);
      dec_s  = $signed({2'b00, decel_step});
      acc_s  = $signed({2'b00, accel_step});
      acur   = abs_wide(cur);
      atgt   = abs_wide(tgt);
      dv     = tgt - cur;
      adv    = abs_wide(dv);
      oppose = (cur < 0 && tgt > 0) || (cur > 0 && tgt < 0);
      step_s = (atgt > acur) ? acc_s : dec_s;
      step_u = step_s[WIDE_W-2:0];
      if (oppose) begin
         if (acur <= {1'b0, decel_step})
            vel_in = '0;
         else if (cur > 0)
            vel_in = CMD_W'(cur - dec_s);
         else
            vel_in = CMD_W'(cur + dec_s);
      end else if (atgt == acur) begin
         vel_in = q_cmd.fwd_target;
      end else if (adv <= step_u) begin
         vel_in = q_cmd.fwd_target;
      end else if (dv > 0) begin
         vel_in = CMD_W'(cur + step_s);
      end else begin
         vel_in = CMD_W'(cur - step_s);
      end
   end

   // gait phase: quotient/remainder tracking of count*65536/period
   always_comb begin
      gcnt_inc = gcnt_ff + 1'b1;
      rem_sum  = {1'b0, gr_ff} + (GCNT_W+1)'(PHASE_REM);
      phase    = '0;
      gcnt_in  = '0;
      gq_in    = '0;
      gr_in    = '0;
      if (q_cmd.gait) begin
         phase = gq_ff;
         if (gcnt_inc != GCNT_W'(GAIT_PERIOD_TICKS)) begin
            gcnt_in = gcnt_inc;
            if (rem_sum >= (GCNT_W+1)'(GAIT_PERIOD_TICKS)) begin
               gr_in = GCNT_W'(rem_sum - (GCNT_W+1)'(GAIT_PERIOD_TICKS));
               gq_in = gq_ff + LEVEL_W'(PHASE_INC) + 1'b1;
            end else begin
               gr_in = rem_sum[GCNT_W-1:0];
               gq_in = gq_ff + LEVEL_W'(PHASE_INC);
            end
         end
      end
      latch_in     = latch_ff || q_cmd.ab_pressed;
      out_valid_in = q_valid || (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_fwd_ff   <= vel_in;
         out_turn_ff  <= q_cmd.turn;
         out_gait_ff  <= q_cmd.gait;
         out_phase_ff <= phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_ff       <= '0;
         gcnt_ff      <= '0;
         gq_ff        <= '0;
         gr_ff        <= '0;
         latch_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (q_pop) begin
            vel_ff   <= vel_in;
            gcnt_ff  <= gcnt_in;
            gq_ff    <= gq_in;
            gr_ff    <= gr_in;
            latch_ff <= latch_in;
         end
      end
   end

endmodule

// ===== rtl/core/joystick_velocity_command_shaper.sv =====
// Gamepad velocity command shaper. One request per control tick carries the stick, trigger
// and button levels (unsigned Q0.16, pressed at or above half scale); each request yields
// one response with the slew-limited forward velocity, the turn rate, the gait phase and
// the A+B latch. A request is taken every clock while the queue has room: the front end
// classifies it in the cycle it arrives and writes it into a two-entry queue, and the back
// end applies one queued command per cycle, unless the response side stalls, to the
// velocity, gait and latch state and registers the response; a request thus passes a queue
// slot and the response register. Registers (APB, byte address 4*i): 0 deadband_width,
// 1 accel_step, 2 decel_step; write them only while no request is in flight.
module joystick_velocity_command_shaper
   import jvcs_pkg::*;
#(
   parameter int unsigned GAIT_PERIOD_TICKS = 60
) (
   input  logic              clock,
   input  logic              reset,
   jvcs_req_channel.sink     req_bus,
   jvcs_rsp_channel.source   rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   cfg_type cfg;
   cmd_type push_cmd;
   cmd_type pop_cmd;
   logic    push;
   logic    push_ready;
   logic    pop;
   logic    pop_valid;

   jvcs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   jvcs_front u_front (
      .req            (req_bus),
      .deadband_width (cfg.deadband_width),
      .q_ready        (push_ready),
      .q_push         (push),
      .q_cmd          (push_cmd)
   );

   jvcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd)
   );

   jvcs_back #(
      .GAIT_PERIOD_TICKS (GAIT_PERIOD_TICKS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .accel_step (cfg.accel_step),
      .decel_step (cfg.decel_step),
      .q_valid    (pop_valid),
      .q_cmd      (pop_cmd),
      .q_pop      (pop),
      .rsp        (rsp_bus)
   );

endmodule

// ===== sim/joystick_velocity_command_shaper_checker.sv =====
module joystick_velocity_command_shaper_checker
   import jvcs_pkg::*;
#(
   parameter int unsigned GAIT_TICKS = 60
) (
   input  logic              clock,
   input  logic              reset,
   jvcs_req_channel          req_mon,
   jvcs_rsp_channel          rsp_mon,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   input  logic [CSR_DW-1:0] prdata,
   input  logic              pready,
   output int                mismatch_count,
   output int                awaiting
);

   typedef struct packed {
      logic signed [CMD_W-1:0] velocity;
      logic signed [CMD_W-1:0] turn;
      logic                    gait_on;
      logic [15:0]             phase;
      logic                    latched;
   } shaper_result_type;

   cfg_type                 cfg;
   logic signed [CMD_W-1:0] velocity;
   logic [GCNT_W-1:0]       gait_count;
   logic                    latched;
   shaper_result_type       results_due[$];
   int                      fails = 0;

   function automatic bit pressed(logic [LEVEL_W-1:0] level);
      return level[LEVEL_W-1];
   endfunction

   function automatic int shaped_axis(logic [LEVEL_W-1:0] raw, bit hold, bit enable, int band);
      int d;
      int mag;
      d = 32768 - int'(raw);
      mag = (d < 0) ? -d : d;
      if (hold || !enable || mag <= band) return 0;
      return d / 2;
   endfunction

   function automatic int slew_toward(int cur, int tgt, int up, int down);
      int step;
      int cur_mag;
      int tgt_mag;
      int dv;
      cur_mag = (cur < 0) ? -cur : cur;
      tgt_mag = (tgt < 0) ? -tgt : tgt;
      // opposite signs: brake toward zero first
      if ((cur < 0 && tgt > 0) || (cur > 0 && tgt < 0)) begin
         if (cur_mag <= down) return 0;
         return (cur > 0) ? cur - down : cur + down;
      end
      if (tgt_mag > cur_mag) step = up;
      else if (tgt_mag < cur_mag) step = down;
      else return tgt;
      dv = tgt - cur;
      if (((dv < 0) ? -dv : dv) <= step) return tgt;
      return (dv > 0) ? cur + step : cur - step;
   endfunction

   task automatic flag(string what, logic [CSR_DW-1:0] want, logic [CSR_DW-1:0] got);
      if (fails < 10) $display("%s mismatch: expected %h, got %h", what, want, got);
      fails++;
   endtask

   task automatic watch_csr();
      if (psel && penable && pready) begin
         if (pwrite) begin
            case (paddr[CSR_AW-1:2])
               REG_DEADBAND: cfg.deadband_width = pwdata[DBAND_W-1:0];
               REG_ACCEL:    cfg.accel_step     = pwdata[STEP_W-1:0];
               REG_DECEL:    cfg.decel_step     = pwdata[STEP_W-1:0];
               default: ;
            endcase
         end else begin
            case (paddr[CSR_AW-1:2])
               REG_DEADBAND: if (prdata !== CSR_DW'(cfg.deadband_width))
                  flag("deadband_width read", CSR_DW'(cfg.deadband_width), prdata);
               REG_ACCEL: if (prdata !== CSR_DW'(cfg.accel_step))
                  flag("accel_step read", CSR_DW'(cfg.accel_step), prdata);
               REG_DECEL: if (prdata !== CSR_DW'(cfg.decel_step))
                  flag("decel_step read", CSR_DW'(cfg.decel_step), prdata);
               default: ;
            endcase
         end
      end
   endtask

   task automatic predict_request();
      shaper_result_type r;
      int                target;
      int                c;
      bit                gait;
      gait = pressed(req_mon.gait_trigger);
      target = shaped_axis(req_mon.stick_forward, pressed(req_mon.hold_forward_button),
                           pressed(req_mon.enable_trigger), int'(cfg.deadband_width));
      r.turn = CMD_W'(shaped_axis(req_mon.stick_turn, pressed(req_mon.hold_turn_button),
                                  pressed(req_mon.enable_trigger), int'(cfg.deadband_width)));
      r.phase = '0;
      if (gait) begin
         c = int'(gait_count);
         if (c >= GAIT_TICKS) c = 0;
         r.phase = 16'((c * 65536) / GAIT_TICKS);
         c++;
         if (c >= GAIT_TICKS) c = 0;
         gait_count = GCNT_W'(c);
      end else begin
         gait_count = '0;
      end
      if (pressed(req_mon.button_a) && pressed(req_mon.button_b)) latched = 1'b1;
      velocity = CMD_W'(slew_toward(int'(velocity), target,
                                    int'(cfg.accel_step), int'(cfg.decel_step)));
      r.velocity = velocity;
      r.gait_on = gait;
      r.latched = latched;
      results_due.push_back(r);
   endtask

   task automatic compare_response();
      shaper_result_type w;
      if (results_due.size() == 0) begin
         if (fails < 10) $display("response with no request outstanding");
         fails++;
      end else begin
         w = results_due.pop_front();
         if (rsp_mon.forward_velocity !== w.velocity)
            flag("forward_velocity", CSR_DW'(w.velocity), CSR_DW'(rsp_mon.forward_velocity));
         if (rsp_mon.turn_rate !== w.turn)
            flag("turn_rate", CSR_DW'(w.turn), CSR_DW'(rsp_mon.turn_rate));
         if (rsp_mon.gait_active !== w.gait_on)
            flag("gait_active", CSR_DW'(w.gait_on), CSR_DW'(rsp_mon.gait_active));
         if (rsp_mon.stride_phase !== w.phase)
            flag("stride_phase", CSR_DW'(w.phase), CSR_DW'(rsp_mon.stride_phase));
         if (rsp_mon.learned_mode !== w.latched)
            flag("learned_mode", CSR_DW'(w.latched), CSR_DW'(rsp_mon.learned_mode));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.deadband_width = DBAND_RESET;
         cfg.accel_step = ACCEL_RESET;
         cfg.decel_step = DECEL_RESET;
         velocity = '0;
         gait_count = '0;
         latched = 1'b0;
         results_due.delete();
      end else begin
         watch_csr();
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) predict_request();
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) compare_response();
      end
      mismatch_count <= fails;
      awaiting <= results_due.size();
   end

endmodule

// ===== sim/joystick_velocity_command_shaper_tb.sv =====
module joystick_velocity_command_shaper_tb;
   import jvcs_pkg::*;

   localparam int unsigned GAIT_TICKS = 60;
   localparam logic [15:0] ZERO   = 16'h0000;
   localparam logic [15:0] LIFT   = 16'h7FFF;
   localparam logic [15:0] PRESS  = 16'h8000;
   localparam logic [15:0] CENTER = 16'h8000;
   localparam logic [15:0] FULL   = 16'hFFFF;
   localparam logic [CSR_AW-1:0] UNMAPPED_ADDR = 4'hC;

   typedef struct packed {
      logic [15:0] stick_forward;
      logic [15:0] stick_turn;
      logic [15:0] enable_trigger;
      logic [15:0] gait_trigger;
      logic [15:0] button_a;
      logic [15:0] button_b;
      logic [15:0] hold_forward;
      logic [15:0] hold_turn;
   } pad_sample_type;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;
   int                mismatches;
   int                in_flight;

   bit          jitter_on = 1'b1;
   bit          hold_rsp = 1'b0;
   int          cur_band = int'(DBAND_RESET);
   int          fwd_left = 0;
   int          gait_left = 0;
   int          enable_left = 0;
   logic [15:0] fwd_keep;
   logic [15:0] gait_keep;
   logic [15:0] enable_keep;
   int          band_set[6] = '{0, 32767, 200, 1500, 6554, 0};
   int          up_set[6]   = '{65535, 1200, 0, 900, 33, 0};
   int          down_set[6] = '{65535, 3000, 700, 0, 98, 0};

   jvcs_req_channel req_if ();
   jvcs_rsp_channel rsp_if ();

   joystick_velocity_command_shaper #(
      .GAIT_PERIOD_TICKS(GAIT_TICKS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   joystick_velocity_command_shaper_checker #(
      .GAIT_TICKS(GAIT_TICKS)
   ) command_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .mismatch_count (mismatches),
      .awaiting       (in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("joystick_velocity_command_shaper verification failed");
      $finish;
   end

   // response side: random stalls, or one long hold-off on request
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            for (int i = 0; i < 150; i++) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_if.ready <= !jitter_on || ($urandom_range(99) >= 35);
         end
      end
   end

   function automatic logic [CSR_AW-1:0] reg_addr(reg_index_type idx);
      return CSR_AW'(idx) << 2;
   endfunction

   function automatic logic [15:0] pick_level(int pct);
      bit down;
      down = $urandom_range(99) < pct;
      if ($urandom_range(7) == 0) return down ? PRESS : LIFT;
      return down ? 16'($urandom_range(32768, 65535)) : 16'($urandom_range(0, 32767));
   endfunction

   function automatic logic [15:0] pick_stick(int band);
      int v;
      case ($urandom_range(5))
         0: v = $urandom_range(1) ? 0 : 65535;
         1: v = $urandom_range(1) ? 32768 - band : 32768 + band;
         2: v = $urandom_range(1) ? 32767 - band : 32769 + band;
         3: v = 28768 + int'($urandom_range(8000));
         default: v = int'($urandom_range(65535));
      endcase
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return 16'(v);
   endfunction

   task automatic next_random_sample(output pad_sample_type s);
      if ($urandom_range(99) < 15) begin
         s = pad_sample_type'({$urandom, $urandom, $urandom, $urandom});
         return;
      end
      if (fwd_left == 0) begin
         fwd_keep = pick_stick(cur_band);
         fwd_left = $urandom_range(1, 60);
      end
      if (gait_left == 0) begin
         gait_keep = pick_level(70);
         gait_left = $urandom_range(1, 90);
      end
      if (enable_left == 0) begin
         enable_keep = pick_level(85);
         enable_left = $urandom_range(1, 50);
      end
      fwd_left--;
      gait_left--;
      enable_left--;
      s.stick_forward = fwd_keep;
      s.stick_turn = pick_stick(cur_band);
      s.enable_trigger = enable_keep;
      s.gait_trigger = gait_keep;
      s.button_a = pick_level(40);
      s.button_b = pick_level(40);
      s.hold_forward = pick_level(10);
      s.hold_turn = pick_level(10);
   endtask

   task automatic offer(input pad_sample_type s);
      if (jitter_on) begin
         while ($urandom_range(99) < 35) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid <= 1'b1;
      req_if.stick_forward <= s.stick_forward;
      req_if.stick_turn <= s.stick_turn;
      req_if.enable_trigger <= s.enable_trigger;
      req_if.gait_trigger <= s.gait_trigger;
      req_if.button_a <= s.button_a;
      req_if.button_b <= s.button_b;
      req_if.hold_forward_button <= s.hold_forward;
      req_if.hold_turn_button <= s.hold_turn;
      do @(posedge clock); while (req_if.ready !== 1'b1);
   endtask

   task automatic offer_levels(input logic [15:0] fwd, turn, en, gait, a, b, hf, ht);
      offer('{fwd, turn, en, gait, a, b, hf, ht});
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic [CSR_AW-1:0] addr, input bit wr,
                             input logic [CSR_DW-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic csr_read_all();
      csr_access(reg_addr(REG_DEADBAND), 1'b0, '0);
      csr_access(reg_addr(REG_ACCEL), 1'b0, '0);
      csr_access(reg_addr(REG_DECEL), 1'b0, '0);
   endtask

   initial begin
      pad_sample_type s;
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_if.valid <= 1'b0;
      req_if.stick_forward <= '0;
      req_if.stick_turn <= '0;
      req_if.enable_trigger <= '0;
      req_if.gait_trigger <= '0;
      req_if.button_a <= '0;
      req_if.button_b <= '0;
      req_if.hold_forward_button <= '0;
      req_if.hold_turn_button <= '0;
      band_set[5] = $urandom_range(0, 32767);
      up_set[5] = $urandom_range(0, 65535);
      down_set[5] = $urandom_range(0, 65535);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_read_all();

      // directed requests at reset settings
      offer_levels(ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO);
      offer_levels(ZERO, FULL, FULL, ZERO, ZERO, ZERO, ZERO, ZERO);
      offer_levels(ZERO, FULL, PRESS, ZERO, ZERO, ZERO, ZERO, ZERO);
      offer_levels(FULL, ZERO, PRESS, ZERO, ZERO, ZERO, ZERO, ZERO);
      offer_levels(FULL, ZERO, LIFT, ZERO, ZERO, ZERO, ZERO, ZERO);
      offer_levels(16'(CENTER - DBAND_RESET), 16'(CENTER + DBAND_RESET), FULL,
                   ZERO, ZERO, ZERO, ZERO, ZERO);
      offer_levels(16'(CENTER - DBAND_RESET - 16'd1), 16'(CENTER + DBAND_RESET + 16'd1), FULL,
                   ZERO, ZERO, ZERO, ZERO, ZERO);
      offer_levels(ZERO, ZERO, FULL, ZERO, ZERO, ZERO, PRESS, LIFT);
      offer_levels(ZERO, ZERO, FULL, ZERO, ZERO, ZERO, LIFT, FULL);
      repeat (3) offer_levels(CENTER, CENTER, ZERO, PRESS, ZERO, ZERO, ZERO, ZERO);
      offer_levels(CENTER, CENTER, ZERO, LIFT, ZERO, ZERO, ZERO, ZERO);
      repeat (2) offer_levels(CENTER, CENTER, ZERO, FULL, ZERO, ZERO, ZERO, ZERO);
      offer_levels(CENTER, CENTER, ZERO, ZERO, PRESS, LIFT, ZERO, ZERO);
      offer_levels(CENTER, CENTER, ZERO, ZERO, LIFT, PRESS, ZERO, ZERO);
      offer_levels(CENTER, CENTER, ZERO, ZERO, FULL, PRESS, ZERO, ZERO);
      offer_levels(CENTER, CENTER, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO);

      for (int p = 0; p < 6; p++) begin
         settle();
         csr_access(reg_addr(REG_DEADBAND), 1'b1, CSR_DW'(band_set[p]));
         csr_access(reg_addr(REG_ACCEL), 1'b1, CSR_DW'(up_set[p]));
         csr_access(reg_addr(REG_DECEL), 1'b1, CSR_DW'(down_set[p]));
         if (p == 0) csr_access(UNMAPPED_ADDR, 1'b1, '1);
         csr_read_all();
         cur_band = band_set[p];
         jitter_on = (p != 2);
         for (int i = 0; i < 140; i++) begin
            if (p == 1 && i == 40) hold_rsp = 1'b1;
            if (p == 3 && i == 70) settle();
            next_random_sample(s);
            offer(s);
         end
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 2000 && in_flight != 0; i++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && in_flight == 0) begin
         $display("joystick_velocity_command_shaper verification clean");
      end else begin
         $display("joystick_velocity_command_shaper verification failed");
      end
      $finish;
   end

endmodule

// ===== joystick_velocity_command_shaper.f =====
rtl/core/jvcs_pkg.sv
rtl/core/jvcs_if.sv
rtl/core/jvcs_csr.sv
rtl/core/jvcs_front.sv
rtl/core/jvcs_queue.sv
rtl/core/jvcs_back.sv
rtl/core/joystick_velocity_command_shaper.sv
sim/joystick_velocity_command_shaper_checker.sv
sim/joystick_velocity_command_shaper_tb.sv
